// File: hw/rtl/deq_pkg.sv
package deq_pkg;

    localparam int DEPTH = 1024;
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int DATA_W = 32;

    localparam logic [3:0] REQ_PUSH_FRONT = 4'd0;
    localparam logic [3:0] REQ_PUSH_BACK  = 4'd1;
    localparam logic [3:0] REQ_POP_FRONT  = 4'd2;
    localparam logic [3:0] REQ_POP_BACK   = 4'd3;
    localparam logic [3:0] REQ_FRONT      = 4'd4;
    localparam logic [3:0] REQ_BACK       = 4'd5;
    localparam logic [3:0] REQ_SIZE       = 4'd6;
    localparam logic [3:0] REQ_CLEAR      = 4'd7;
    localparam logic [3:0] REQ_END        = 4'd8;

    localparam logic [2:0] ST_OK    = 3'd0;
    localparam logic [2:0] ST_VALUE = 3'd1;
    localparam logic [2:0] ST_EMPTY = 3'd2;
    localparam logic [2:0] ST_FULL  = 3'd3;
    localparam logic [2:0] ST_BYE   = 3'd4;

    typedef logic [PTR_W-1:0] t_ptr;
    typedef logic [CNT_W-1:0] t_cnt;

    // Slot that lies off places after idx, both below DEPTH.
    function automatic t_ptr slot_after(input t_ptr idx, input t_ptr off);
        logic [PTR_W:0] sum;
        sum = {1'b0, idx} + {1'b0, off};
        if (sum >= (PTR_W + 1)'(DEPTH)) begin
            sum = sum - (PTR_W + 1)'(DEPTH);
        end
        return sum[PTR_W-1:0];
    endfunction

endpackage

// File: hw/rtl/double_ended_queue.sv
// Channel   Direction  Handshake                  Payload
// request   in         i_in_valid / o_in_ready     i_req_type, i_push_value
// result    out        o_out_valid / i_out_ready   o_status, o_result_value
//
// Every request beat yields exactly one result beat, in the cycle after it is taken.
// A request is taken in every cycle in which the result register is empty or
// drained in that cycle, so the sustained rate is one beat per cycle.
// The element memory has a single port: each request reads or writes at most one slot.
// Reset clears the head pointer, the count and the result valid flag only.
// When the result side stalls, the request side stalls with it.
module double_ended_queue
    import deq_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_in_valid,
    output logic                     o_in_ready,
    input  logic [3:0]               i_req_type,
    input  logic signed [DATA_W-1:0] i_push_value,
    output logic                     o_out_valid,
    input  logic                     i_out_ready,
    output logic [2:0]               o_status,
    output logic signed [DATA_W-1:0] o_result_value
);

    // Element storage: one synchronous port, read data registered.
    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rd_data;

    t_ptr              r_head, n_head;
    t_cnt              r_count, n_count;
    logic              r_out_valid, n_out_valid;
    logic [2:0]        r_status, n_status;
    logic [DATA_W-1:0] r_value, n_value;
    logic              r_use_mem, n_use_mem;

    logic   w_fire;
    logic   w_mem_we;
    logic   w_mem_re;
    t_ptr   w_mem_addr;
    logic   w_empty;
    logic   w_full;
    t_ptr   w_back_off;

    // The result register is a one-entry stage; a new request may enter
    // in the same cycle in which the waiting result is taken.
    assign o_in_ready = !r_out_valid || i_out_ready;
    assign w_fire     = i_in_valid && o_in_ready;

    assign w_empty = (r_count == '0);
    assign w_full  = (r_count == CNT_W'(DEPTH));

    // Offset of the back word from the head, valid whenever the queue is not empty.
    assign w_back_off = PTR_W'(r_count - CNT_W'(1));

    always_comb begin
        n_head      = r_head;
        n_count     = r_count;
        n_status    = r_status;
        n_value     = r_value;
        n_use_mem   = r_use_mem;
        n_out_valid = r_out_valid;
        w_mem_we    = 1'b0;
        w_mem_re    = 1'b0;
        w_mem_addr  = r_head;

        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        if (w_fire) begin
            n_out_valid = 1'b1;
            n_status    = ST_OK;
            n_value     = '0;
            n_use_mem   = 1'b0;
            unique case (i_req_type)
                REQ_PUSH_FRONT: begin
                    if (w_full) begin
                        n_status = ST_FULL;
                    end else begin
                        // Step the head back one slot, wrapping at zero.
                        n_head     = (r_head == '0) ? PTR_W'(DEPTH - 1) : r_head - PTR_W'(1);
                        w_mem_addr = n_head;
                        w_mem_we   = 1'b1;
                        n_count    = r_count + CNT_W'(1);
                    end
                end
                REQ_PUSH_BACK: begin
                    if (w_full) begin
                        n_status = ST_FULL;
                    end else begin
                        w_mem_addr = slot_after(r_head, PTR_W'(r_count));
                        w_mem_we   = 1'b1;
                        n_count    = r_count + CNT_W'(1);
                    end
                end
                REQ_POP_FRONT, REQ_FRONT: begin
                    if (w_empty) begin
                        n_status = ST_EMPTY;
                    end else begin
                        n_status   = ST_VALUE;
                        n_use_mem  = 1'b1;
                        w_mem_addr = r_head;
                        w_mem_re   = 1'b1;
                        if (i_req_type == REQ_POP_FRONT) begin
                            n_head  = slot_after(r_head, PTR_W'(1));
                            n_count = r_count - CNT_W'(1);
                        end
                    end
                end
                REQ_POP_BACK, REQ_BACK: begin
                    if (w_empty) begin
                        n_status = ST_EMPTY;
                    end else begin
                        n_status   = ST_VALUE;
                        n_use_mem  = 1'b1;
                        w_mem_addr = slot_after(r_head, w_back_off);
                        w_mem_re   = 1'b1;
                        if (i_req_type == REQ_POP_BACK) begin
                            n_count = r_count - CNT_W'(1);
                        end
                    end
                end
                REQ_SIZE: begin
                    n_status = ST_VALUE;
                    n_value  = DATA_W'(r_count);
                end
                REQ_CLEAR: begin
                    n_head  = '0;
                    n_count = '0;
                end
                default: begin
                    // End and the unused codes only say goodbye.
                    n_status = ST_BYE;
                end
            endcase
        end
    end

    // A slot written by one request is read at the earliest by the next one,
    // so the single port never sees a read and a write together.
    always_ff @(posedge i_clk) begin
        if (w_mem_we) begin
            r_mem[w_mem_addr] <= i_push_value;
        end
        if (w_mem_re) begin
            r_rd_data <= r_mem[w_mem_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head      <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_head      <= n_head;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    // Result payload; it changes only when a new request is taken.
    always_ff @(posedge i_clk) begin
        r_status  <= n_status;
        r_value   <= n_value;
        r_use_mem <= n_use_mem;
    end

    assign o_out_valid    = r_out_valid;
    assign o_status       = r_status;
    assign o_result_value = r_use_mem ? signed'(r_rd_data) : signed'(r_value);

endmodule
